// ===== src/bgd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgd_pkg: shared types and constants of the button gesture detector
// Timing constants, register indexes, event codes, reset values, the register file type and the handoff type.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int TIME_BITS_DEF   = 48;
  // Buttons that the register file and the level input can describe.
  localparam int HW_BUTTONS      = 4;

  localparam int unsigned DEBOUNCE_US       = 20000;
  localparam int unsigned DOUBLE_US         = 400000;
  localparam int unsigned CLICK_QUIET_US    = 350000;
  localparam int unsigned US_PER_MS         = 1000;
  localparam int unsigned DEFAULT_REPEAT_MS = 120;

  // Width of a 16-bit millisecond value scaled to microseconds.
  localparam int US_W = 26;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MASK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_3       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd6;

  localparam logic [1:0] EV_CLICK  = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_REPEAT = 2'd3;

  localparam logic [2:0]  RST_BUTTON_COUNT = 3'd4;
  localparam logic [3:0]  RST_LOW_MASK     = 4'hF;
  localparam logic [15:0] RST_HOLD_SHORT   = 16'd450;
  localparam logic [15:0] RST_HOLD_LONG    = 16'd3000;
  localparam logic [15:0] RST_REPEAT       = 16'd120;

  typedef struct packed {
    logic [2:0]                   button_count;
    logic [HW_BUTTONS-1:0]        low_mask;
    logic [HW_BUTTONS-1:0][15:0]  long_hold;
    logic [15:0]                  period_ms;
  } cfg_t;

  // Events of one finished poll, passed from the walker to the emitter.
  typedef struct packed {
    logic                        valid;
    logic [HW_BUTTONS-1:0]       mask;
    logic [HW_BUTTONS-1:0][1:0]  kinds;
  } handoff_t;

endpackage

// ===== src/bgd_if.sv =====
// ----------------------------------------------------------------------------
// bgd_if: channel interfaces of the button gesture detector
// Poll input, event output and register write channels.
// ----------------------------------------------------------------------------
interface bgd_poll_if #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           button_levels;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output button_levels, output now_us, input ready);
  modport sink   (input valid, input button_levels, input now_us, output ready);
endinterface

interface bgd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] button_index;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output button_index, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input last_event, output ready);
endinterface

interface bgd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bgd_pkg::CFG_IDX_W-1:0]   index;
  logic [bgd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bgd_state_mem.sv =====
// ----------------------------------------------------------------------------
// bgd_state_mem: per-button state memory
// One write and one read port, registered read data. Entries read as zero
// until their first write.
// ----------------------------------------------------------------------------
module bgd_state_mem #(
  parameter int DEPTH  = 4,
  parameter int IDX_W  = 2,
  parameter int DATA_W = 197
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== src/bgd_walker.sv =====
// ----------------------------------------------------------------------------
// bgd_walker: per-poll walk over the buttons
// Three-stage read, elapsed-time and update pipeline over the state memory,
// one button entering per cycle. Events are collected per button.
// ----------------------------------------------------------------------------
module bgd_walker #(
  parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bgd_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bgd_poll_if.sink          poll,
  input  bgd_pkg::cfg_t     cfg,
  input  logic              emit_free,
  output bgd_pkg::handoff_t handoff
);

  localparam int LIMIT = (NUM_BUTTONS < bgd_pkg::HW_BUTTONS) ? NUM_BUTTONS
                                                               : bgd_pkg::HW_BUTTONS;
  localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int ENT_W = 4 * TIME_BITS + 5;
  localparam logic [2:0] LIMIT3 = 3'(LIMIT);
  localparam int US_W = bgd_pkg::US_W;

  typedef struct packed {
    logic [TIME_BITS-1:0] change_time;
    logic [TIME_BITS-1:0] click_time;
    logic [TIME_BITS-1:0] repeat_time;
    logic [TIME_BITS-1:0] press_start;
    logic [1:0]           clicks;
    logic                 long_done;
    logic                 press_active;
    logic                 down;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HAND = 3'b100
  } state_t;

  state_t               state;
  logic [3:0]           levels_r;
  logic [TIME_BITS-1:0] now_r;
  logic [2:0]           cnt_r;
  logic [2:0]           rd_cnt;
  logic                 rd_go;

  logic                 s1_v;
  logic [IDX_W-1:0]     s1_idx;
  entry_t               rd_ent;
  logic [ENT_W-1:0]     rd_data;
  logic [1:0]           s1_sel;
  logic [15:0]          rep_ms;

  logic                 s2_v;
  logic [IDX_W-1:0]     s2_idx;
  entry_t               s2_ent;
  logic                 s2_down;
  logic [TIME_BITS-1:0] s2_e_chg;
  logic [TIME_BITS-1:0] s2_e_clk;
  logic [TIME_BITS-1:0] s2_e_prs;
  logic [TIME_BITS-1:0] s2_e_rep;
  logic [US_W-1:0]      s2_hold_us;
  logic [US_W-1:0]      s2_rep_us;

  entry_t               nxt;
  logic                 trans;
  logic                 skip;
  logic                 press_new;
  logic                 click_new;
  logic [2:0]           clicks3;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] clk_el;
  logic [TIME_BITS-1:0] hold_ext;
  logic [TIME_BITS-1:0] rep_ext;
  logic                 fire;
  logic [1:0]           kind;
  logic                 wr_en;

  logic [bgd_pkg::HW_BUTTONS-1:0]      ev_mask;
  logic [bgd_pkg::HW_BUTTONS-1:0][1:0] ev_kind;

  assign poll.ready = (state == ST_IDLE);
  assign rd_go      = (state == ST_RUN) && (rd_cnt < cnt_r);

  bgd_state_mem #(
    .DEPTH  (LIMIT),
    .IDX_W  (IDX_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_go),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s2_idx),
    .wr_data (nxt)
  );

  assign rd_ent = entry_t'(rd_data);
  assign s1_sel = 2'(s1_idx);
  assign rep_ms = (cfg.period_ms == 16'd0) ? 16'(bgd_pkg::DEFAULT_REPEAT_MS)
                                           : cfg.period_ms;

  // Sequencer and read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
    end else begin
      s1_v <= rd_go;
      s2_v <= s1_v;
      case (state)
        ST_IDLE: begin
          if (poll.valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!rd_go && !s1_v && !s2_v) begin
            state <= ST_HAND;
          end
        end
        ST_HAND: begin
          if (emit_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      levels_r <= poll.button_levels;
      now_r    <= poll.now_us;
      cnt_r    <= (cfg.button_count > LIMIT3) ? LIMIT3 : cfg.button_count;
      rd_cnt   <= 3'd0;
    end else if (rd_go) begin
      rd_cnt <= rd_cnt + 3'd1;
    end
    s1_idx <= rd_cnt[IDX_W-1:0];
  end

  // Elapsed-time stage: all differences against the stored times.
  always_ff @(posedge clk) begin
    s2_idx     <= s1_idx;
    s2_ent     <= rd_ent;
    s2_down    <= levels_r[s1_sel] ^ cfg.low_mask[s1_sel];
    s2_e_chg   <= now_r - rd_ent.change_time;
    s2_e_clk   <= now_r - rd_ent.click_time;
    s2_e_prs   <= now_r - rd_ent.press_start;
    s2_e_rep   <= now_r - rd_ent.repeat_time;
    s2_hold_us <= US_W'(cfg.long_hold[s1_sel]) * US_W'(bgd_pkg::US_PER_MS);
    s2_rep_us  <= US_W'(rep_ms) * US_W'(bgd_pkg::US_PER_MS);
  end

  assign hold_ext = TIME_BITS'(s2_hold_us);
  assign rep_ext  = TIME_BITS'(s2_rep_us);

  // Update stage: debounce, press and release handling, event choice.
  always_comb begin
    nxt       = s2_ent;
    fire      = 1'b0;
    kind      = bgd_pkg::EV_CLICK;
    press_new = 1'b0;
    click_new = 1'b0;
    clicks3   = 3'd1;
    trans     = (s2_down != s2_ent.down);
    skip      = trans && (s2_e_chg < TIME_BITS'(bgd_pkg::DEBOUNCE_US));

    if (trans && !skip) begin
      nxt.change_time = now_r;
      nxt.down        = s2_down;
      if (s2_down) begin
        press_new        = 1'b1;
        nxt.press_active = 1'b1;
        nxt.long_done    = 1'b0;
        nxt.press_start  = now_r;
        nxt.repeat_time  = '0;
      end else if (s2_ent.press_active) begin
        nxt.press_active = 1'b0;
        if (s2_ent.long_done) begin
          nxt.long_done = 1'b0;
          nxt.clicks    = 2'd0;
        end else begin
          if (s2_ent.clicks != 2'd0 && s2_e_clk < TIME_BITS'(bgd_pkg::DOUBLE_US)) begin
            clicks3 = {1'b0, s2_ent.clicks} + 3'd1;
          end
          click_new      = 1'b1;
          nxt.click_time = now_r;
          if (clicks3 >= 3'd2) begin
            fire       = 1'b1;
            kind       = bgd_pkg::EV_DOUBLE;
            nxt.clicks = 2'd0;
          end else begin
            nxt.clicks = clicks3[1:0];
          end
        end
      end
    end

    // A press taken in this poll has been held for no time at all.
    held = press_new ? '0 : s2_e_prs;
    if (nxt.press_active && nxt.down) begin
      if (!nxt.long_done && held >= hold_ext) begin
        nxt.long_done   = 1'b1;
        nxt.repeat_time = now_r;
        fire            = 1'b1;
        kind            = bgd_pkg::EV_LONG;
      end else if (nxt.long_done && s2_e_rep >= rep_ext) begin
        nxt.repeat_time = now_r;
        fire            = 1'b1;
        kind            = bgd_pkg::EV_REPEAT;
      end
    end

    clk_el = click_new ? '0 : s2_e_clk;
    if (!nxt.press_active && nxt.clicks == 2'd1 &&
        clk_el > TIME_BITS'(bgd_pkg::CLICK_QUIET_US)) begin
      fire       = 1'b1;
      kind       = bgd_pkg::EV_CLICK;
      nxt.clicks = 2'd0;
    end

    // A button still bouncing is left untouched for this poll.
    if (skip) begin
      fire = 1'b0;
    end
  end

  assign wr_en = s2_v && !skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_mask <= '0;
    end else if (poll.valid && poll.ready) begin
      ev_mask <= '0;
    end else if (s2_v && fire) begin
      ev_mask[2'(s2_idx)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && fire) begin
      ev_kind[2'(s2_idx)] <= kind;
    end
  end

  assign handoff.valid = (state == ST_HAND) && emit_free;
  assign handoff.mask  = ev_mask;
  assign handoff.kinds = ev_kind;

endmodule

// ===== src/bgd_emitter.sv =====
// ----------------------------------------------------------------------------
// bgd_emitter: event output queue
// Holds the events of one poll and sends them in button order through an
// output register, marking the last one.
// ----------------------------------------------------------------------------
module bgd_emitter (
  input  logic              clk,
  input  logic              rst,
  input  bgd_pkg::handoff_t handoff,
  output logic              emit_free,
  bgd_event_if.source       evt
);

  localparam int HW = bgd_pkg::HW_BUTTONS;

  logic [HW-1:0]      mask;
  logic [HW-1:0]      mask_next;
  logic [HW-1:0][1:0] kinds;
  logic [HW-1:0]      sel;
  logic [HW-1:0]      rest;
  logic [1:0]         k;
  logic               take;
  logic               out_valid;
  logic [1:0]         out_index;
  logic [1:0]         out_kind;
  logic               out_last;

  assign emit_free = (mask == '0);
  assign take      = !out_valid || evt.ready;

  // Lowest pending button goes first.
  assign sel  = mask & (~mask + HW'(1));
  assign rest = mask & ~sel;

  always_comb begin
    k = 2'd0;
    for (int i = 0; i < HW; i++) begin
      if (sel[i]) begin
        k = 2'(i);
      end
    end
  end

  always_comb begin
    mask_next = mask;
    if (handoff.valid) begin
      mask_next = handoff.mask;
    end else if (take && mask != '0) begin
      mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= mask_next;
      if (take) begin
        out_valid <= (mask != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (handoff.valid) begin
      kinds <= handoff.kinds;
    end
    if (take && mask != '0) begin
      out_index <= k;
      out_kind  <= kinds[k];
      out_last  <= (rest == '0);
    end
  end

  assign evt.valid        = out_valid;
  assign evt.button_index = out_index;
  assign evt.event_kind   = out_kind;
  assign evt.last_event   = out_last;

endmodule

// ===== src/button_gesture_detector.sv =====
// ----------------------------------------------------------------------------
// button_gesture_detector: click, double click and long-press detector
// Debounces up to four buttons per poll and reports one gesture event per
// button at most, in button order.
//
//   channel | direction | moves
//   --------+-----------+----------------------------------------------
//   poll    | in        | one item: button levels and microsecond time
//   evt     | out       | one item per event: button, kind, last flag
//   cfg     | in        | register writes, always ready
//
// A poll takes the enabled buttons one per cycle through a three-stage
// read, elapsed-time and update pipeline on the state memory; the next
// poll is accepted after the walk, with a wait while the previous poll's
// events are still queued. Events leave at one per cycle unless stalled.
// Reset is synchronous; button state reads as released and zero afterwards.
// A stalled output holds its item; a poll may be walked meanwhile, but waits to hand off.
// ----------------------------------------------------------------------------
module button_gesture_detector #(
  parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF,
  parameter int TIME_BITS   = bgd_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bgd_poll_if.sink    poll,
  bgd_event_if.source evt,
  bgd_cfg_if.sink     cfg
);

  bgd_pkg::cfg_t     regs;
  bgd_pkg::handoff_t handoff;
  logic              emit_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.button_count <= bgd_pkg::RST_BUTTON_COUNT;
      regs.low_mask     <= bgd_pkg::RST_LOW_MASK;
      regs.long_hold[0] <= bgd_pkg::RST_HOLD_SHORT;
      regs.long_hold[1] <= bgd_pkg::RST_HOLD_SHORT;
      regs.long_hold[2] <= bgd_pkg::RST_HOLD_SHORT;
      regs.long_hold[3] <= bgd_pkg::RST_HOLD_LONG;
      regs.period_ms    <= bgd_pkg::RST_REPEAT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bgd_pkg::REG_BUTTON_COUNT: regs.button_count <= cfg.data[2:0];
        bgd_pkg::REG_LOW_MASK:     regs.low_mask     <= cfg.data[3:0];
        bgd_pkg::REG_HOLD_0:       regs.long_hold[0] <= cfg.data;
        bgd_pkg::REG_HOLD_1:       regs.long_hold[1] <= cfg.data;
        bgd_pkg::REG_HOLD_2:       regs.long_hold[2] <= cfg.data;
        bgd_pkg::REG_HOLD_3:       regs.long_hold[3] <= cfg.data;
        bgd_pkg::REG_REPEAT:       regs.period_ms    <= cfg.data;
        default: ;
      endcase
    end
  end

  bgd_walker #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll),
    .cfg       (regs),
    .emit_free (emit_free),
    .handoff   (handoff)
  );

  bgd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .handoff   (handoff),
    .emit_free (emit_free),
    .evt       (evt)
  );

endmodule
